@@ design/tdq_pkg.sv @@
// Shared types and codes for the term deque with match removal.
`default_nettype none
package tdq_pkg;

	typedef struct packed {
		logic [15:0] degree;
		logic signed [31:0] coef;
	} term_t;

	localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [2:0] KIND_POP_BACK   = 3'd2;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [2:0] KIND_REMOVE     = 3'd4;
	localparam logic [2:0] KIND_SEARCH     = 3'd5;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam int unsigned TALLY_W = 7;
	localparam logic [6:0] TALLY_MAX = 7'd127;

endpackage
`default_nettype wire

@@ design/tdq_store.sv @@
// Term store: one write port and one read port with registered read data.
`default_nettype none
module tdq_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input  wire              clk,
	input  wire              wr_en,
	input  wire [AW-1:0]     wr_addr,
	input  tdq_pkg::term_t   wr_data,
	input  wire [AW-1:0]     rd_addr,
	output tdq_pkg::term_t   rd_data
);

	tdq_pkg::term_t mem_q [DEPTH];
	tdq_pkg::term_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ design/term_deque_with_match_removal_unit.sv @@
// Top level: bounded deque of terms with removal and search of matching entries.
// A word is accepted only while idle. A push or other non-walking word passes through the
// execute and finish states; a pop also passes a read state for the store's registered read.
// Remove and search walk one entry per cycle before the finish state; a search stops at its
// first match. The finish state waits for a free output register, and the next word is taken
// once it returns to idle. Reset clears pointers, count, sequencer, out_valid and result regs.
`default_nettype none
module term_deque_with_match_removal_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [2:0]         kind,
	input  wire  [15:0]        term_degree,
	input  wire  signed [31:0] term_coef,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [15:0]        out_degree,
	output logic signed [31:0] out_coef,
	output logic [6:0]         tally,
	output logic               found,
	output logic [1:0]         status
);

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = (CW > tdq_pkg::TALLY_W) ? CW : tdq_pkg::TALLY_W;
	localparam logic [IW:0] CAP_W = (IW + 1)'(CAPACITY);
	localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_POPRD = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]      state_q;
	logic [IW-1:0]   front_q;
	logic [CW-1:0]   count_q;
	logic [2:0]      op_kind_q;
	tdq_pkg::term_t  op_term_q;
	logic [IW-1:0]   rd_ptr_q;
	logic [IW-1:0]   wr_ptr_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   kept_q;
	logic [CW-1:0]   removed_q;

	logic [15:0]        res_deg_q;
	logic signed [31:0] res_coef_q;
	logic [6:0]         res_tally_q;
	logic               res_found_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [IW-1:0]      mem_raddr;
	tdq_pkg::term_t     mem_wdata;
	tdq_pkg::term_t     mem_rdata;

	logic [IW:0]    sum_back;
	logic [IW:0]    sum_last;
	logic [IW-1:0]  back_slot;
	logic [IW-1:0]  last_slot;
	logic [IW-1:0]  front_dec;
	logic [IW-1:0]  front_inc;
	logic [IW-1:0]  rd_inc;
	logic [IW-1:0]  wr_inc;
	logic           is_full;
	logic           is_empty;
	logic           match;
	logic           walk_last;
	logic [CW-1:0]  idx_next;
	logic [CW-1:0]  removed_fin;
	logic [CW-1:0]  kept_fin;
	logic           in_take;
	logic           out_take;

	function automatic logic [6:0] sat_tally(input logic [CW-1:0] v);
		logic [SW-1:0] ext;
		ext = SW'(v);
		sat_tally = (ext > SW'(tdq_pkg::TALLY_MAX)) ? tdq_pkg::TALLY_MAX : ext[6:0];
	endfunction

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
		wrap_inc = (p == LAST_SLOT) ? '0 : p + IW'(1);
	endfunction

	// Slot positions are taken modulo CAPACITY by one compare and subtract.
	always_comb begin
		sum_back = (IW + 1)'(front_q) + (IW + 1)'(count_q);
		sum_last = sum_back - (IW + 1)'(1);
		back_slot = (sum_back >= CAP_W) ? IW'(sum_back - CAP_W) : IW'(sum_back);
		last_slot = (sum_last >= CAP_W) ? IW'(sum_last - CAP_W) : IW'(sum_last);
		front_dec = (front_q == '0) ? LAST_SLOT : front_q - IW'(1);
		front_inc = wrap_inc(front_q);
		rd_inc = wrap_inc(rd_ptr_q);
		wr_inc = wrap_inc(wr_ptr_q);
		is_full = (count_q == CAP_C);
		is_empty = (count_q == '0);
		match = (mem_rdata == op_term_q);
		idx_next = idx_q + CW'(1);
		walk_last = (idx_next == count_q);
		removed_fin = removed_q + CW'(match);
		kept_fin = kept_q + CW'(!match);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = mem_rdata;
		mem_raddr = front_q;
		unique case (state_q)
			S_EXEC: begin
				if ((op_kind_q == tdq_pkg::KIND_PUSH_BACK ||
						op_kind_q == tdq_pkg::KIND_PUSH_FRONT) && !is_full) begin
					mem_we = 1'b1;
					mem_waddr = (op_kind_q == tdq_pkg::KIND_PUSH_BACK) ? back_slot : front_dec;
					mem_wdata = op_term_q;
				end
				mem_raddr = (op_kind_q == tdq_pkg::KIND_POP_BACK) ? last_slot : front_q;
			end
			S_WALK: begin
				// Entries that survive removal close up behind the read pointer.
				mem_we = (op_kind_q == tdq_pkg::KIND_REMOVE) && !match;
				mem_raddr = rd_ptr_q;
			end
			default: begin
			end
		endcase
	end

	tdq_store #(
		.DEPTH(CAPACITY),
		.AW(IW)
	) u_store (
		.clk(clk),
		.wr_en(mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_kind_q <= kind;
			op_term_q <= {term_degree, term_coef};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			idx_q <= '0;
			kept_q <= '0;
			removed_q <= '0;
			res_deg_q <= '0;
			res_coef_q <= '0;
			res_tally_q <= '0;
			res_found_q <= 1'b0;
			res_status_q <= tdq_pkg::STATUS_OK;
		end else begin
			if (out_take && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_deg_q <= '0;
					res_coef_q <= '0;
					res_tally_q <= '0;
					res_found_q <= 1'b0;
					rd_ptr_q <= front_inc;
					wr_ptr_q <= front_q;
					idx_q <= '0;
					kept_q <= '0;
					removed_q <= '0;
					unique case (op_kind_q)
						tdq_pkg::KIND_PUSH_BACK, tdq_pkg::KIND_PUSH_FRONT: begin
							state_q <= S_FIN;
							if (is_full) begin
								res_status_q <= tdq_pkg::STATUS_FULL;
							end else begin
								res_status_q <= tdq_pkg::STATUS_OK;
								count_q <= count_q + CW'(1);
								if (op_kind_q == tdq_pkg::KIND_PUSH_FRONT) begin
									front_q <= front_dec;
								end
							end
						end
						tdq_pkg::KIND_POP_BACK, tdq_pkg::KIND_POP_FRONT: begin
							if (is_empty) begin
								res_status_q <= tdq_pkg::STATUS_EMPTY;
								state_q <= S_FIN;
							end else begin
								res_status_q <= tdq_pkg::STATUS_OK;
								count_q <= count_q - CW'(1);
								if (op_kind_q == tdq_pkg::KIND_POP_FRONT) begin
									front_q <= front_inc;
								end
								state_q <= S_POPRD;
							end
						end
						tdq_pkg::KIND_REMOVE, tdq_pkg::KIND_SEARCH: begin
							res_status_q <= tdq_pkg::STATUS_OK;
							state_q <= is_empty ? S_FIN : S_WALK;
						end
						default: begin
							res_status_q <= tdq_pkg::STATUS_OK;
							state_q <= S_FIN;
						end
					endcase
				end
				S_POPRD: begin
					res_deg_q <= mem_rdata.degree;
					res_coef_q <= mem_rdata.coef;
					state_q <= S_FIN;
				end
				S_WALK: begin
					rd_ptr_q <= rd_inc;
					idx_q <= idx_next;
					removed_q <= removed_fin;
					kept_q <= kept_fin;
					if (!match) begin
						wr_ptr_q <= wr_inc;
					end
					if (op_kind_q == tdq_pkg::KIND_SEARCH) begin
						if (match) begin
							res_found_q <= 1'b1;
							res_tally_q <= sat_tally(idx_q);
							state_q <= S_FIN;
						end else if (walk_last) begin
							state_q <= S_FIN;
						end
					end else if (walk_last) begin
						count_q <= kept_fin;
						res_tally_q <= sat_tally(removed_fin);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_stall == 1'b0) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The result word moves into the output register when that register is free.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			out_degree <= res_deg_q;
			out_coef <= res_coef_q;
			tally <= res_tally_q;
			found <= res_found_q;
			status <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
